// ===== hw/rtl/rar_pkg.sv =====
// Package for the rational arithmetic reducer: payload structs, operation codes,
// and the controller-to-datapath command and status structs. No dependencies.
`default_nettype none
package rar_pkg;

    localparam int OpW  = 16;
    localparam int NumW = 33;
    localparam int DenW = 31;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]            operation;
        logic signed [OpW-1:0] left_numerator;
        logic signed [OpW-1:0] left_denominator;
        logic signed [OpW-1:0] right_numerator;
        logic signed [OpW-1:0] right_denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [NumW-1:0] result_numerator;
        logic [DenW-1:0]        result_denominator;
        logic                   error;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic combine;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic finish;
    } rar_cmd_t;

    typedef struct packed {
        logic error;
        logic gcd_done;
        logic div_done;
    } rar_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rar_datapath.sv =====
// Datapath: operand decode, sequential cross products, binary GCD and
// restoring division by the GCD. Depends on rar_pkg.
`default_nettype none
module rar_datapath (
    input  wire logic               clk,
    input  wire rar_pkg::in_item_t  in_item,
    input  wire rar_pkg::rar_cmd_t  cmd,
    output rar_pkg::rar_sts_t       sts,
    output rar_pkg::out_item_t      res
);
    import rar_pkg::*;

    localparam int PW = 2*OpW;     // product magnitude width
    localparam int SW = PW + 1;    // sum magnitude width
    localparam int KW = $clog2(SW + 1);
    localparam int CW = $clog2(SW + 1);

    logic [1:0]     op_reg;
    logic           ln_neg_reg, rn_neg_reg;
    logic [OpW:0]   ln_reg, ld_reg, rn_reg, rd_reg;
    logic           err_reg;
    logic [PW-1:0]  p0_reg, p1_reg, pd_reg;
    logic           p0n_reg, p1n_reg;
    logic           num_neg_reg;
    logic [SW-1:0]  nmag_reg, dmag_reg;
    logic [SW-1:0]  ga_reg, gb_reg;
    logic [KW-1:0]  gk_reg;
    logic [SW-1:0]  g_reg;
    logic [SW-1:0]  qn_reg, qd_reg, rn_rem_reg, rd_rem_reg;
    logic [CW-1:0]  dcnt_reg;
    out_item_t      res_reg;

    function automatic logic [OpW:0] mag_of(input logic [OpW-1:0] v);
        logic [OpW:0] e;
        e = {v[OpW-1], v};
        return v[OpW-1] ? (~e + 1'b1) : e;
    endfunction

    // operand decode, sign moved off denominators
    logic [OpW:0] ln_m, ld_m, rn_m, rd_m;
    logic         dec_err;
    always_comb
    begin
        ln_m = mag_of(in_item.left_numerator);
        ld_m = mag_of(in_item.left_denominator);
        rn_m = mag_of(in_item.right_numerator);
        rd_m = mag_of(in_item.right_denominator);
        dec_err = (ld_m == '0) || (rd_m == '0) ||
                  ((in_item.operation == OP_DIV) && (rn_m == '0));
    end

    // combine the products into numerator and denominator magnitudes
    logic [SW-1:0] a_s, b_s, sum_m;
    logic          a_n, b_n, sum_n;
    always_comb
    begin
        a_s = {1'b0, p0_reg};
        b_s = {1'b0, p1_reg};
        a_n = p0n_reg;
        b_n = p1n_reg ^ (op_reg == OP_SUB);
        if (a_n == b_n)
        begin
            sum_m = a_s + b_s;
            sum_n = a_n;
        end
        else if (a_s >= b_s)
        begin
            sum_m = a_s - b_s;
            sum_n = a_n;
        end
        else
        begin
            sum_m = b_s - a_s;
            sum_n = b_n;
        end
        if (sum_m == '0)
            sum_n = 1'b0;
    end

    // binary gcd step
    logic [SW-1:0] ga_n, gb_n;
    logic [KW-1:0] gk_n;
    always_comb
    begin
        ga_n = ga_reg;
        gb_n = gb_reg;
        gk_n = gk_reg;
        if (ga_reg == '0 || gb_reg == '0)
        begin
            ga_n = ga_reg;
        end
        else if (!ga_reg[0] && !gb_reg[0])
        begin
            ga_n = ga_reg >> 1;
            gb_n = gb_reg >> 1;
            gk_n = gk_reg + 1'b1;
        end
        else if (!ga_reg[0])
            ga_n = ga_reg >> 1;
        else if (!gb_reg[0])
            gb_n = gb_reg >> 1;
        else if (ga_reg >= gb_reg)
            ga_n = (ga_reg - gb_reg) >> 1;
        else
            gb_n = (gb_reg - ga_reg) >> 1;
    end

    // restoring division, numerator and denominator in parallel
    logic [SW:0]   trn, trd;
    logic [SW-1:0] rn_nx, rd_nx;
    always_comb
    begin
        trn = {rn_rem_reg, qn_reg[SW-1]};
        trd = {rd_rem_reg, qd_reg[SW-1]};
        rn_nx = (trn >= {1'b0, g_reg}) ? SW'(trn - {1'b0, g_reg}) : trn[SW-1:0];
        rd_nx = (trd >= {1'b0, g_reg}) ? SW'(trd - {1'b0, g_reg}) : trd[SW-1:0];
    end

    logic [SW-1:0] sgn_num;
    always_comb
    begin
        sgn_num = num_neg_reg ? (~qn_reg + 1'b1) : qn_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_item.operation;
            ln_reg     <= ln_m;
            ld_reg     <= ld_m;
            rn_reg     <= rn_m;
            rd_reg     <= rd_m;
            ln_neg_reg <= (in_item.left_numerator[OpW-1] ^ in_item.left_denominator[OpW-1])
                          && (ln_m != '0);
            rn_neg_reg <= (in_item.right_numerator[OpW-1] ^ in_item.right_denominator[OpW-1])
                          && (rn_m != '0);
            err_reg    <= dec_err;
        end
        if (cmd.mul1)
        begin
            // left cross product
            p0_reg  <= PW'(ln_reg * ((op_reg == OP_MUL) ? rn_reg : rd_reg));
            p0n_reg <= ln_neg_reg ^ ((op_reg == OP_MUL) ? rn_neg_reg : 1'b0);
        end
        if (cmd.mul2)
        begin
            p1_reg  <= PW'(rn_reg * ld_reg);
            p1n_reg <= rn_neg_reg;
            pd_reg  <= PW'(ld_reg * ((op_reg == OP_DIV) ? rn_reg : rd_reg));
        end
        if (cmd.combine)
        begin
            if (op_reg == OP_ADD || op_reg == OP_SUB)
            begin
                nmag_reg    <= sum_m;
                num_neg_reg <= sum_n;
            end
            else
            begin
                nmag_reg    <= {1'b0, p0_reg};
                num_neg_reg <= (p0_reg != '0) &&
                               (p0n_reg ^ ((op_reg == OP_DIV) ? rn_neg_reg : 1'b0));
            end
            dmag_reg <= {1'b0, pd_reg};
            ga_reg   <= (op_reg == OP_ADD || op_reg == OP_SUB) ? sum_m : {1'b0, p0_reg};
            gb_reg   <= {1'b0, pd_reg};
            gk_reg   <= '0;
        end
        if (cmd.gcd_step)
        begin
            ga_reg <= ga_n;
            gb_reg <= gb_n;
            gk_reg <= gk_n;
        end
        if (cmd.div_start)
        begin
            g_reg      <= ((ga_reg | gb_reg) << gk_reg);
            qn_reg     <= nmag_reg;
            qd_reg     <= dmag_reg;
            rn_rem_reg <= '0;
            rd_rem_reg <= '0;
            dcnt_reg   <= CW'(SW);
        end
        if (cmd.div_step)
        begin
            rn_rem_reg <= rn_nx;
            rd_rem_reg <= rd_nx;
            qn_reg     <= {qn_reg[SW-2:0], (trn >= {1'b0, g_reg})};
            qd_reg     <= {qd_reg[SW-2:0], (trd >= {1'b0, g_reg})};
            dcnt_reg   <= dcnt_reg - 1'b1;
        end
        if (cmd.finish)
        begin
            if (err_reg)
            begin
                res_reg.result_numerator   <= '0;
                res_reg.result_denominator <= '0;
                res_reg.error              <= 1'b1;
            end
            else
            begin
                res_reg.result_numerator   <= NumW'(sgn_num);
                res_reg.result_denominator <= DenW'(qd_reg);
                res_reg.error              <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.error    = err_reg;
        sts.gcd_done = (ga_reg == '0) || (gb_reg == '0);
        sts.div_done = (dcnt_reg == '0);
        res          = res_reg;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rar_ctrl.sv =====
// Controller: sequences load, products, gcd, division and output handshake.
// Depends on rar_pkg.
`default_nettype none
module rar_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire rar_pkg::rar_sts_t sts,
    output rar_pkg::rar_cmd_t      cmd
);
    import rar_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_COMB = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ov_next    = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        in_ready = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = sts.error ? S_FIN : S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next  = S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DIV:
            begin
                if (sts.div_done)
                    state_next = S_FIN;
                else
                    cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                // wait until the output register is free
                if (!ov_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rational_arith_reduce.sv =====
// Rational arithmetic with GCD reduction: one result transaction per input transaction.
// Steps: load, cross products, combine, binary-GCD steps, division by the GCD, finish;
// an error transaction goes from the first product straight to finish. One transaction in
// flight; a result held in the output register delays only the finish.
// Reset (rst_n, asynchronous, active low) idles the controller and drops any pending result.
// Depends on rar_pkg, rar_ctrl, rar_datapath.
`default_nettype none
module rational_arith_reduce (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rar_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rar_pkg::out_item_t      out_data
);
    import rar_pkg::*;

    rar_cmd_t cmd;
    rar_sts_t sts;

    // sequence the transaction
    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hold operands, reduce, and register the result
    rar_datapath u_dp (
        .clk     (clk),
        .in_item (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .res     (out_data)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/rar_checker.sv =====
// Port checker for rational_arith_reduce, bound to the top level.
// Depends on rar_pkg.
`default_nettype none
module rar_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire rar_pkg::out_item_t out_data
);
    import rar_pkg::*;

    // a held result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // an error result is 0/0
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |->
            out_data.result_numerator == '0 && out_data.result_denominator == '0)
        else $error("error result not 0/0");

    // a good result has a positive denominator
    a_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.error |-> out_data.result_denominator != '0)
        else $error("zero denominator without error");

    // accepted input is not ready again next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

endmodule

bind rational_arith_reduce rar_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
